/* src/ahfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ahfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam int ACK_LEN         = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] HEX_ALPHA_GAP = 8'd7;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDR_HI = 3'd1,
    PH_ADDR_LO = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CK_HI   = 3'd4,
    PH_CK_LO   = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADSTART = 3'd1,
    ST_BADADDR  = 3'd2,
    ST_BADCKSUM = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  // one classified received character
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] digit;
    logic       is_dollar;
    logic       is_hash;
    logic       is_cr;
    logic       is_lf;
  } tok_t;

  // no range check: anything above '9' is taken as an uppercase letter
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (c > CH_NINE) begin
      d = d - HEX_ALPHA_GAP;
    end
    return d;
  endfunction

  function automatic logic [7:0] ack_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h4B;
      3'd3:    c = 8'h30;
      3'd4:    c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/ahfp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahfp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  output logic               tok_valid,
  input  wire logic          tok_ready,
  output ahfp_pkg::tok_t     tok
);

  logic           stg_valid_r;
  logic           stg_valid_nxt;
  ahfp_pkg::tok_t stg_tok_r;
  ahfp_pkg::tok_t stg_tok_nxt;
  logic           load;

  assign in_ready = !stg_valid_r || tok_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    stg_tok_nxt.data      = in_rx_byte;
    stg_tok_nxt.digit     = ahfp_pkg::hex_digit(in_rx_byte);
    stg_tok_nxt.is_dollar = (in_rx_byte == ahfp_pkg::CH_DOLLAR);
    stg_tok_nxt.is_hash   = (in_rx_byte == ahfp_pkg::CH_HASH);
    stg_tok_nxt.is_cr     = (in_rx_byte == ahfp_pkg::CH_CR);
    stg_tok_nxt.is_lf     = (in_rx_byte == ahfp_pkg::CH_LF);
    if (load) begin
      stg_valid_nxt = 1'b1;
    end else if (tok_ready) begin
      stg_valid_nxt = 1'b0;
    end else begin
      stg_valid_nxt = stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stg_tok_r <= stg_tok_nxt;
    end
  end

  assign tok_valid = stg_valid_r;
  assign tok       = stg_tok_r;

endmodule
`default_nettype wire

/* src/ahfp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahfp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire ahfp_pkg::tok_t push_tok,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output ahfp_pkg::tok_t      pop_tok
);

  localparam int Depth = ahfp_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ahfp_pkg::tok_t  slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = slot_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

/* src/ahfp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahfp_back #(
  parameter int MAX_PAYLOAD = ahfp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [7:0]     cfg_wr_data,
  input  wire logic           tok_valid,
  output logic                tok_ready,
  input  wire ahfp_pkg::tok_t tok,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_kind,
  output logic [7:0]          out_payload_byte,
  output logic [2:0]          out_status,
  output logic [6:0]          out_payload_length,
  output logic                out_ack_seen
);

  localparam logic [6:0] MaxLen = 7'(MAX_PAYLOAD);
  localparam logic [2:0] AckLen = 3'(ahfp_pkg::ACK_LEN);

  ahfp_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        own_addr_r;
  logic [7:0]        sum_r, sum_nxt;
  logic [3:0]        nib_r, nib_nxt;
  logic [6:0]        len_r, len_nxt;
  logic [2:0]        ack_prog_r, ack_prog_nxt;
  logic              ack_ok_r, ack_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  ahfp_pkg::kind_t   kind_r, kind_nxt;
  logic [7:0]        byte_r, byte_nxt;
  ahfp_pkg::status_t status_r, status_nxt;
  logic [6:0]        olen_r, olen_nxt;
  logic              oack_r, oack_nxt;

  logic              take;
  logic              emit;
  logic [7:0]        hex_val;
  logic              ack_hit;

  assign tok_ready = !out_valid_r || out_ready;
  assign take      = tok_valid && tok_ready;
  assign hex_val   = {nib_r, 4'b0000} + tok.digit;
  assign ack_hit   = ack_ok_r && (ack_prog_r < AckLen) &&
                     (tok.data == ahfp_pkg::ack_char(ack_prog_r));

  always_comb begin
    phase_nxt    = phase_r;
    sum_nxt      = sum_r;
    nib_nxt      = nib_r;
    len_nxt      = len_r;
    ack_prog_nxt = ack_prog_r;
    ack_ok_nxt   = ack_ok_r;
    emit         = 1'b0;
    kind_nxt     = ahfp_pkg::KIND_STATUS;
    byte_nxt     = 8'h00;
    status_nxt   = ahfp_pkg::ST_OK;
    olen_nxt     = 7'd0;
    oack_nxt     = 1'b0;
    if (take) begin
      case (phase_r)
        ahfp_pkg::PH_ADDR_HI: begin
          nib_nxt   = tok.digit[3:0];
          sum_nxt   = sum_r + tok.data;
          phase_nxt = ahfp_pkg::PH_ADDR_LO;
        end
        ahfp_pkg::PH_ADDR_LO: begin
          sum_nxt = sum_r + tok.data;
          if (hex_val != own_addr_r) begin
            phase_nxt  = ahfp_pkg::PH_DISCARD;
            emit       = 1'b1;
            status_nxt = ahfp_pkg::ST_BADADDR;
          end else begin
            phase_nxt = ahfp_pkg::PH_PAYLOAD;
          end
        end
        ahfp_pkg::PH_PAYLOAD: begin
          if (tok.is_hash) begin
            phase_nxt = ahfp_pkg::PH_CK_HI;
          end else if (len_r >= MaxLen) begin
            phase_nxt  = ahfp_pkg::PH_DISCARD;
            emit       = 1'b1;
            status_nxt = ahfp_pkg::ST_OVERFLOW;
            olen_nxt   = MaxLen;
          end else begin
            sum_nxt  = sum_r + tok.data;
            len_nxt  = len_r + 7'd1;
            if (ack_hit) begin
              ack_prog_nxt = ack_prog_r + 3'd1;
            end else begin
              ack_ok_nxt = 1'b0;
            end
            emit     = 1'b1;
            kind_nxt = ahfp_pkg::KIND_PAYLOAD;
            byte_nxt = tok.data;
          end
        end
        ahfp_pkg::PH_CK_HI: begin
          nib_nxt   = tok.digit[3:0];
          phase_nxt = ahfp_pkg::PH_CK_LO;
        end
        ahfp_pkg::PH_CK_LO: begin
          phase_nxt  = ahfp_pkg::PH_IDLE;
          emit       = 1'b1;
          status_nxt = (hex_val == sum_r) ? ahfp_pkg::ST_OK : ahfp_pkg::ST_BADCKSUM;
          olen_nxt   = len_r;
          oack_nxt   = ack_ok_r && (ack_prog_r == AckLen) && (len_r == 7'(ahfp_pkg::ACK_LEN));
        end
        ahfp_pkg::PH_DISCARD: begin
          if (tok.is_cr) begin
            phase_nxt = ahfp_pkg::PH_IDLE;
          end
        end
        default: begin
          // idle, and the unused phase code
          if (tok.is_cr || tok.is_lf) begin
            phase_nxt = ahfp_pkg::PH_IDLE;
          end else if (tok.is_dollar) begin
            phase_nxt    = ahfp_pkg::PH_ADDR_HI;
            sum_nxt      = 8'h00;
            nib_nxt      = 4'h0;
            len_nxt      = 7'd0;
            ack_prog_nxt = 3'd0;
            ack_ok_nxt   = 1'b1;
          end else begin
            phase_nxt  = ahfp_pkg::PH_DISCARD;
            emit       = 1'b1;
            status_nxt = ahfp_pkg::ST_BADSTART;
          end
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ahfp_pkg::PH_IDLE;
      own_addr_r  <= 8'h00;
      sum_r       <= 8'h00;
      nib_r       <= 4'h0;
      len_r       <= 7'd0;
      ack_prog_r  <= 3'd0;
      ack_ok_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      nib_r       <= nib_nxt;
      len_r       <= len_nxt;
      ack_prog_r  <= ack_prog_nxt;
      ack_ok_r    <= ack_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        own_addr_r <= cfg_wr_data;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r   <= kind_nxt;
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      olen_r   <= olen_nxt;
      oack_r   <= oack_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_status         = status_r;
  assign out_payload_length = olen_r;
  assign out_ack_seen       = oack_r;

endmodule
`default_nettype wire

/* src/ascii_hex_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// Parser for '$' AA payload '#' CC reply frames arriving one character per
// transaction. Takes one character per clock cycle, sustained, as long as the
// result side keeps up; the figure is set by the frame parser, which steps
// once per character. A character goes through the classifier register, a
// QUEUE_DEPTH-entry queue and the parser's result register before its result
// shows up. Each payload character is delivered as a result of kind 0; a
// status result (kind 1) closes every frame, good or bad. After a bad start,
// wrong address or overflow, characters are dropped up to and including the
// next CR. Write own_address only while the block is idle.
module ascii_hex_frame_parser #(
  parameter int MAX_PAYLOAD = ahfp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic [7:0]      out_payload_byte,
  output logic [2:0]      out_status,
  output logic [6:0]      out_payload_length,
  output logic            out_ack_seen
);

  logic           fr_valid;
  logic           fr_ready;
  ahfp_pkg::tok_t fr_tok;
  logic           bk_valid;
  logic           bk_ready;
  ahfp_pkg::tok_t bk_tok;

  ahfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .tok_valid  (fr_valid),
    .tok_ready  (fr_ready),
    .tok        (fr_tok)
  );

  ahfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_tok   (fr_tok),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_tok    (bk_tok)
  );

  ahfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .tok_valid          (bk_valid),
    .tok_ready          (bk_ready),
    .tok                (bk_tok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .out_ack_seen       (out_ack_seen)
  );

endmodule
`default_nettype wire

/* src/ahfp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahfp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_kind,
  input wire logic [7:0] out_payload_byte,
  input wire logic [2:0] out_status,
  input wire logic [6:0] out_payload_length,
  input wire logic       out_ack_seen
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_payload_byte) && $stable(out_status) &&
      $stable(out_payload_length) && $stable(out_ack_seen))
    else $error("result changed while stalled");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ahfp_pkg::KIND_PAYLOAD |->
      out_status == ahfp_pkg::ST_OK && out_payload_length == 7'd0 && !out_ack_seen)
    else $error("payload result carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ahfp_pkg::KIND_STATUS |-> out_payload_byte == 8'h00)
    else $error("status result carries a payload character");

  a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_seen |-> out_kind == ahfp_pkg::KIND_STATUS &&
      out_payload_length == 7'd5 &&
      (out_status == ahfp_pkg::ST_OK || out_status == ahfp_pkg::ST_BADCKSUM))
    else $error("ack flag on a frame that cannot hold ACK00");

  a_early_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ahfp_pkg::KIND_STATUS &&
      (out_status == ahfp_pkg::ST_BADSTART || out_status == ahfp_pkg::ST_BADADDR)
      |-> out_payload_length == 7'd0)
    else $error("nonzero length on a frame rejected before its payload");

endmodule

bind ascii_hex_frame_parser ahfp_checker u_ahfp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_payload_byte   (out_payload_byte),
  .out_status         (out_status),
  .out_payload_length (out_payload_length),
  .out_ack_seen       (out_ack_seen)
);
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_LEN       = ahfp_pkg::MAX_PAYLOAD_DEF;
  localparam int HANG_LIMIT    = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_CHARS   = 160;
  // "ACK00", first character in the top byte
  localparam logic [39:0] ACK_WORD = 40'h41434B3030;

  typedef struct packed {
    ahfp_pkg::kind_t   kind;
    logic [7:0]        data;
    ahfp_pkg::status_t status;
    logic [6:0]        length;
    logic              ack;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic [2:0] out_status;
  logic [6:0] out_payload_length;
  logic       out_ack_seen;

  logic [7:0] char_q[$];
  logic [7:0] body_q[$];
  reply_t     reply_q[$];

  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;
  int         quiet_cycles = 0;
  int         err_count = 0;
  int         n_results = 0;
  int         frame_chars = 0;
  logic [7:0] cfg_value = 8'h00;

  // parser state as the block should hold it
  ahfp_pkg::phase_t p_phase = ahfp_pkg::PH_IDLE;
  logic [7:0] p_sum = 8'h00;
  logic [7:0] p_addr = 8'h00;
  logic [3:0] p_hi = 4'h0;
  logic [6:0] p_len = 7'd0;
  logic [2:0] p_ack_pos = 3'd0;
  logic       p_ack_ok = 1'b1;

  ascii_hex_frame_parser uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .out_ack_seen       (out_ack_seen)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c - 8'h30 : c - 8'h37;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic flag_error(input string what);
    $display("tb_top: mismatch at result %0d: %s", n_results, what);
    err_count++;
  endtask

  // advance the expected parser by one character, queue what it emits
  task automatic parse_char(input logic [7:0] c);
    reply_t     r;
    logic [7:0] v;
    bit         emit;
    emit = 1'b0;
    r = '0;
    case (p_phase)
      ahfp_pkg::PH_ADDR_HI: begin
        v = hex_val(c);
        p_hi = v[3:0];
        p_sum = p_sum + c;
        p_phase = ahfp_pkg::PH_ADDR_LO;
      end
      ahfp_pkg::PH_ADDR_LO: begin
        p_sum = p_sum + c;
        v = {p_hi, 4'h0} + hex_val(c);
        if (v != p_addr) begin
          p_phase = ahfp_pkg::PH_DISCARD;
          emit = 1'b1;
          r.kind = ahfp_pkg::KIND_STATUS;
          r.status = ahfp_pkg::ST_BADADDR;
        end else begin
          p_phase = ahfp_pkg::PH_PAYLOAD;
        end
      end
      ahfp_pkg::PH_PAYLOAD: begin
        if (c == ahfp_pkg::CH_HASH) begin
          p_phase = ahfp_pkg::PH_CK_HI;
        end else if (p_len >= 7'(MAX_LEN)) begin
          p_phase = ahfp_pkg::PH_DISCARD;
          emit = 1'b1;
          r.kind = ahfp_pkg::KIND_STATUS;
          r.status = ahfp_pkg::ST_OVERFLOW;
          r.length = 7'(MAX_LEN);
        end else begin
          p_sum = p_sum + c;
          p_len = p_len + 7'd1;
          if (p_ack_ok && p_ack_pos < 3'd5 && c == ACK_WORD[39 - 8 * int'(p_ack_pos) -: 8]) begin
            p_ack_pos = p_ack_pos + 3'd1;
          end else begin
            p_ack_ok = 1'b0;
          end
          emit = 1'b1;
          r.kind = ahfp_pkg::KIND_PAYLOAD;
          r.data = c;
        end
      end
      ahfp_pkg::PH_CK_HI: begin
        v = hex_val(c);
        p_hi = v[3:0];
        p_phase = ahfp_pkg::PH_CK_LO;
      end
      ahfp_pkg::PH_CK_LO: begin
        v = {p_hi, 4'h0} + hex_val(c);
        p_phase = ahfp_pkg::PH_IDLE;
        emit = 1'b1;
        r.kind = ahfp_pkg::KIND_STATUS;
        r.status = (v == p_sum) ? ahfp_pkg::ST_OK : ahfp_pkg::ST_BADCKSUM;
        r.length = p_len;
        r.ack = p_ack_ok && p_ack_pos == 3'd5 && p_len == 7'd5;
      end
      ahfp_pkg::PH_DISCARD: begin
        if (c == ahfp_pkg::CH_CR) begin
          p_phase = ahfp_pkg::PH_IDLE;
        end
      end
      default: begin
        if (c == ahfp_pkg::CH_CR || c == ahfp_pkg::CH_LF) begin
          p_phase = ahfp_pkg::PH_IDLE;
        end else if (c == ahfp_pkg::CH_DOLLAR) begin
          p_phase = ahfp_pkg::PH_ADDR_HI;
          p_sum = 8'h00;
          p_hi = 4'h0;
          p_len = 7'd0;
          p_ack_pos = 3'd0;
          p_ack_ok = 1'b1;
        end else begin
          p_phase = ahfp_pkg::PH_DISCARD;
          emit = 1'b1;
          r.kind = ahfp_pkg::KIND_STATUS;
          r.status = ahfp_pkg::ST_BADSTART;
        end
      end
    endcase
    if (emit) begin
      reply_q.push_back(r);
    end
  endtask

  // random payload without '#', so the frame runs to its own end marker
  task automatic fill_body(input int len);
    logic [7:0] c;
    body_q.delete();
    repeat (len) begin
      c = 8'($urandom);
      if (c == ahfp_pkg::CH_HASH) begin
        c = ahfp_pkg::CH_DOLLAR;
      end
      body_q.push_back(c);
    end
  endtask

  task automatic ack_body(input int variant);
    body_q.delete();
    for (int i = 0; i < 5; i++) begin
      body_q.push_back(ACK_WORD[39 - 8 * i -: 8]);
    end
    case (variant)
      1: void'(body_q.pop_back());
      2: body_q.push_back(8'h30);
      3: body_q[$urandom_range(0, 4)] ^= 8'h01;
      default: ;
    endcase
  endtask

  // '$' AA body '#' CC, with a correct checksum unless bad_sum or junk_digits is set
  task automatic send_frame(input logic [7:0] addr, input bit bad_sum, input bit junk_digits);
    logic [7:0] a_hi, a_lo, ck_hi, ck_lo, sum;
    a_hi = hex_char(addr[7:4]);
    a_lo = hex_char(addr[3:0]);
    if (junk_digits) begin
      a_hi = 8'($urandom);
      a_lo = 8'($urandom);
    end
    sum = a_hi + a_lo;
    foreach (body_q[i]) begin
      sum = sum + body_q[i];
    end
    if (bad_sum) begin
      sum = sum ^ (8'd1 << $urandom_range(0, 7));
    end
    ck_hi = junk_digits ? 8'($urandom) : hex_char(sum[7:4]);
    ck_lo = junk_digits ? 8'($urandom) : hex_char(sum[3:0]);
    char_q.push_back(ahfp_pkg::CH_DOLLAR);
    char_q.push_back(a_hi);
    char_q.push_back(a_lo);
    foreach (body_q[i]) begin
      char_q.push_back(body_q[i]);
    end
    char_q.push_back(ahfp_pkg::CH_HASH);
    char_q.push_back(ck_hi);
    char_q.push_back(ck_lo);
    frame_chars += body_q.size() + 6;
  endtask

  task automatic write_addr(input logic [7:0] a);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_addr = a;
    cfg_value = a;
    @(negedge clk);
  endtask

  task automatic run_directed();
    char_q.push_back(ahfp_pkg::CH_CR);
    char_q.push_back(ahfp_pkg::CH_LF);
    fill_body(0);
    send_frame(cfg_value, 1'b0, 1'b0);
    ack_body(0);
    send_frame(cfg_value, 1'b0, 1'b0);
    ack_body(0);
    send_frame(cfg_value, 1'b1, 1'b0);
    ack_body(1);
    send_frame(cfg_value, 1'b0, 1'b0);
    ack_body(2);
    send_frame(cfg_value, 1'b0, 1'b0);
    // control characters are plain data inside a frame
    body_q = '{ahfp_pkg::CH_DOLLAR, ahfp_pkg::CH_CR, ahfp_pkg::CH_LF, 8'h00, 8'hFF, 8'h7F,
               8'h80};
    send_frame(cfg_value, 1'b0, 1'b0);
    fill_body(2);
    send_frame(cfg_value ^ 8'h01, 1'b0, 1'b0);
    char_q.push_back(ahfp_pkg::CH_CR);
    body_q = '{8'h5A, ahfp_pkg::CH_HASH, ahfp_pkg::CH_CR, 8'h00, ahfp_pkg::CH_CR, 8'hFF,
               ahfp_pkg::CH_CR};
    foreach (body_q[i]) begin
      char_q.push_back(body_q[i]);
    end
    fill_body(MAX_LEN);
    send_frame(cfg_value, 1'b0, 1'b0);
    fill_body(MAX_LEN + 1);
    send_frame(cfg_value, 1'b0, 1'b0);
    char_q.push_back(ahfp_pkg::CH_CR);
    fill_body(3);
    send_frame(cfg_value, 1'b0, 1'b1);
    char_q.push_back(ahfp_pkg::CH_CR);
  endtask

  task automatic random_segment(input int budget);
    int stop_at, len, sel;
    stop_at = frame_chars + budget;
    while (frame_chars < stop_at) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_LEN - 8, MAX_LEN + 4)
                                         : $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) begin
        ack_body($urandom_range(0, 3));
      end else begin
        fill_body(len);
      end
      if (sel < 70) begin
        send_frame(cfg_value, $urandom_range(0, 5) == 0, 1'b0);
        if (body_q.size() > MAX_LEN || $urandom_range(0, 2) == 0) begin
          char_q.push_back(ahfp_pkg::CH_CR);
        end
      end else if (sel < 85) begin
        send_frame(cfg_value ^ 8'($urandom_range(1, 255)), 1'b0, 1'b0);
        char_q.push_back(ahfp_pkg::CH_CR);
      end else if (sel < 93) begin
        send_frame(cfg_value, 1'b0, 1'b1);
        char_q.push_back(ahfp_pkg::CH_CR);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          char_q.push_back(8'($urandom));
          frame_chars++;
        end
        if ($urandom_range(0, 1) == 0) begin
          char_q.push_back(ahfp_pkg::CH_LF);
        end
        char_q.push_back(ahfp_pkg::CH_CR);
      end
    end
  endtask

  // hold until every character is taken and every result has come back
  task automatic drain();
    while (char_q.size() != 0 || in_valid || reply_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_rx_byte);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (char_q.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= char_q.pop_front();
          in_gap <= pick_wait(in_calm);
          if ($urandom_range(0, 63) == 0) begin
            in_calm <= ~in_calm;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    int     w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        flag_error("result with nothing expected");
      end else begin
        want = reply_q.pop_front();
        if (out_kind !== want.kind)
          flag_error($sformatf("kind %0b, want %0b", out_kind, want.kind));
        if (out_payload_byte !== want.data)
          flag_error($sformatf("payload_byte %h, want %h", out_payload_byte, want.data));
        if (out_status !== want.status)
          flag_error($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_payload_length !== want.length)
          flag_error($sformatf("payload_length %0d, want %0d", out_payload_length,
                               want.length));
        if (out_ack_seen !== want.ack)
          flag_error($sformatf("ack_seen %0b, want %0b", out_ack_seen, want.ack));
      end
      n_results++;
      w = pick_wait(out_calm);
      if ($urandom_range(0, 63) == 0) begin
        out_calm <= ~out_calm;
      end
      out_stall <= w;
      out_ready <= (w == 0);
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] addr_list[$];
    addr_list = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'($urandom), 8'($urandom), 8'($urandom)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (addr_list[i]) begin
      write_addr(addr_list[i]);
      if (i == 0) begin
        run_directed();
      end
      random_segment(PHASE_CHARS);
      drain();
    end
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
